// ----- rtl/mlprbs_pkg.sv -----
package mlprbs_pkg;

    localparam int SEED_W      = 31;
    localparam int WORD_W      = 32;
    localparam int LANE_IDX_W  = 5;
    localparam int MODE_W      = 2;
    localparam int ORDER_SEL_W = 2;
    localparam int STAGE_IDX_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // item modes
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEED    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GEN     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LANE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_LANES = 2'd2;

    // order selects
    localparam logic [ORDER_SEL_W-1:0] SEL_PRBS7  = 2'd0;
    localparam logic [ORDER_SEL_W-1:0] SEL_PRBS15 = 2'd1;
    localparam logic [ORDER_SEL_W-1:0] SEL_PRBS23 = 2'd2;
    localparam logic [ORDER_SEL_W-1:0] SEL_PRBS31 = 2'd3;

    // standard seed, bit i is stage i
    localparam logic [SEED_W-1:0] STD_SEED = 31'b1100100010111010011101101011111;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [LANE_IDX_W-1:0] lane;
        logic [SEED_W-1:0]     seed;
        logic                  negative_phase;
        logic [WORD_W-1:0]     read_data;
    } cmd_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] pattern;
        logic              mismatch;
        logic [WORD_W-1:0] error_count;
    } rsp_word_t;

    typedef struct packed {
        logic [ORDER_SEL_W-1:0] order_select;
        logic [LANE_IDX_W-1:0]  target_lane;
        logic                   random_lanes;
    } cfg_t;

    typedef struct packed {
        logic                  restart;
        logic                  load;
        logic                  step;
        logic [LANE_IDX_W-1:0] lane;
        logic [SEED_W-1:0]     seed;
    } lane_ctrl_t;

    typedef struct packed {
        logic restart;
        logic gen;
        logic check;
        logic negative_phase;
    } cmp_ctrl_t;

    // largest order select whose length fits in max_order stages
    function automatic logic [ORDER_SEL_W-1:0] max_sel(input int max_order);
        logic [ORDER_SEL_W-1:0] s;
        if (max_order >= 31)
            s = SEL_PRBS31;
        else if (max_order >= 23)
            s = SEL_PRBS23;
        else if (max_order >= 15)
            s = SEL_PRBS15;
        else
            s = SEL_PRBS7;
        return s;
    endfunction

    // oldest stage of the order (output and first tap)
    function automatic logic [STAGE_IDX_W-1:0] out_stage(input logic [ORDER_SEL_W-1:0] sel);
        logic [STAGE_IDX_W-1:0] s;
        case (sel)
            SEL_PRBS7:  s = 5'd6;
            SEL_PRBS15: s = 5'd14;
            SEL_PRBS23: s = 5'd22;
            default:    s = 5'd30;
        endcase
        return s;
    endfunction

    // second tap stage
    function automatic logic [STAGE_IDX_W-1:0] tap_stage(input logic [ORDER_SEL_W-1:0] sel);
        logic [STAGE_IDX_W-1:0] s;
        case (sel)
            SEL_PRBS7:  s = 5'd2;
            SEL_PRBS15: s = 5'd0;
            SEL_PRBS23: s = 5'd4;
            default:    s = 5'd2;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/mlprbs_lanes.sv -----
module mlprbs_lanes #(
    parameter int LANES     = 32,
    parameter int MAX_ORDER = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mlprbs_pkg::lane_ctrl_t          ctrl,
    input  mlprbs_pkg::cfg_t                cfg,
    output logic [mlprbs_pkg::WORD_W-1:0]   word
);
    import mlprbs_pkg::*;

    localparam logic [ORDER_SEL_W-1:0] MAX_SEL = max_sel(MAX_ORDER);

    logic [MAX_ORDER-1:0]   lane_reg  [LANES];
    logic [MAX_ORDER-1:0]   lane_next [LANES];
    logic [LANES-1:0]       out_bits;
    logic [ORDER_SEL_W-1:0] eff_sel;
    logic [STAGE_IDX_W-1:0] o_idx;
    logic [STAGE_IDX_W-1:0] t_idx;
    logic                   load_ok;

    // orders longer than the lane clamp down to the largest that fits
    always_comb
    begin
        eff_sel = (cfg.order_select > MAX_SEL) ? MAX_SEL : cfg.order_select;
        o_idx   = out_stage(eff_sel);
        t_idx   = tap_stage(eff_sel);
        load_ok = ctrl.load && cfg.random_lanes && (ctrl.lane != cfg.target_lane);
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        logic [SEED_W-1:0] r_ext;
        logic              fb;

        always_comb
        begin
            r_ext       = SEED_W'(lane_reg[j]);
            out_bits[j] = r_ext[o_idx];
            fb          = r_ext[o_idx] ^ r_ext[t_idx];
            if (ctrl.restart)
                lane_next[j] = STD_SEED[MAX_ORDER-1:0];
            else if (load_ok && (int'(ctrl.lane) == j))
                lane_next[j] = ctrl.seed[MAX_ORDER-1:0];
            else if (ctrl.step)
                lane_next[j] = {lane_reg[j][MAX_ORDER-2:0], fb};
            else
                lane_next[j] = lane_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                lane_reg[j] <= STD_SEED[MAX_ORDER-1:0];
            else
                lane_reg[j] <= lane_next[j];
        end
    end

    for (genvar b = 0; b < WORD_W; b++)
    begin : g_word
        if (b < LANES)
        begin : g_on
            assign word[b] = out_bits[b];
        end
        else
        begin : g_off
            assign word[b] = 1'b0;
        end
    end

endmodule

// ----- rtl/mlprbs_cmp.sv -----
module mlprbs_cmp #(
    parameter int LANES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mlprbs_pkg::cmp_ctrl_t           ctrl,
    input  mlprbs_pkg::cfg_t                cfg,
    input  logic [mlprbs_pkg::WORD_W-1:0]   word,
    input  logic [mlprbs_pkg::WORD_W-1:0]   read_data,
    output mlprbs_pkg::rsp_word_t           rsp
);
    import mlprbs_pkg::*;

    logic [WORD_W-1:0] count_reg;
    logic [WORD_W-1:0] count_next;
    logic [WORD_W-1:0] inv_mask;
    logic [WORD_W-1:0] pattern;
    logic              mis;

    always_comb
    begin
        inv_mask = '0;
        if (ctrl.negative_phase && (int'(cfg.target_lane) < LANES))
            inv_mask[cfg.target_lane] = 1'b1;
        pattern = ctrl.gen ? (word ^ inv_mask) : '0;
        mis     = ctrl.check && (read_data != pattern);

        // saturating mismatch counter
        if (ctrl.restart)
            count_next = '0;
        else if (mis && (count_reg != '1))
            count_next = count_reg + WORD_W'(1);
        else
            count_next = count_reg;

        rsp.pattern     = pattern;
        rsp.mismatch    = mis;
        rsp.error_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// ----- rtl/multilane_prbs_pattern_gen_check_core.sv -----
// Channel   Handshake              Word type              Direction
// cmd       cmd_valid / cmd_ready  mlprbs_pkg::cmd_word_t  in
// rsp       rsp_valid / rsp_ready  mlprbs_pkg::rsp_word_t  out
// cfg       cfg_we (no wait)       cfg_index, cfg_wdata    in
//
// One cmd word per cycle while rsp_ready stays high; each accepted word
// passes through the input register, then the result register, before it
// shows up as an rsp word.
// The lane update, pattern, compare and counter all happen in the single
// cycle the word moves from the input register to the result register.
// Reset loads the standard seed into every lane, clears the error count and
// sets order_select=0, target_lane=0, random_lanes=1.
// A stalled rsp holds its word; the input register still takes one more cmd
// word, then cmd_ready drops until the result register frees up.
module multilane_prbs_pattern_gen_check_core #(
    parameter int LANES     = 32,
    parameter int MAX_ORDER = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [mlprbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlprbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  mlprbs_pkg::cmd_word_t               cmd,

    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output mlprbs_pkg::rsp_word_t               rsp
);
    import mlprbs_pkg::*;

    // configuration registers
    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    // input register
    cmd_word_t  s1_reg;
    logic       s1_valid_reg;
    logic       s1_valid_next;

    // result register
    rsp_word_t  rsp_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    logic       cmd_fire;
    logic       s1_adv;
    lane_ctrl_t lane_ctrl;
    cmp_ctrl_t  cmp_ctrl;
    logic [WORD_W-1:0] lane_word;
    rsp_word_t  rsp_calc;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORDER_SELECT: cfg_next.order_select = cfg_wdata[ORDER_SEL_W-1:0];
                CFG_TARGET_LANE:  cfg_next.target_lane  = cfg_wdata[LANE_IDX_W-1:0];
                CFG_RANDOM_LANES: cfg_next.random_lanes = cfg_wdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order_select <= SEL_PRBS7;
            cfg_reg.target_lane  <= '0;
            cfg_reg.random_lanes <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // word leaves the input register when the result register is free
    // or being emptied this cycle
    always_comb
    begin
        s1_adv         = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
        cmd_ready      = !s1_valid_reg || s1_adv;
        cmd_fire       = cmd_valid && cmd_ready;
        s1_valid_next  = cmd_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        rsp_valid_next = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    always_comb
    begin
        lane_ctrl.restart = s1_adv && (s1_reg.mode == MODE_RESTART);
        lane_ctrl.load    = s1_adv && (s1_reg.mode == MODE_SEED);
        lane_ctrl.step    = s1_adv && ((s1_reg.mode == MODE_GEN) ||
                                       (s1_reg.mode == MODE_CHECK));
        lane_ctrl.lane    = s1_reg.lane;
        lane_ctrl.seed    = s1_reg.seed;

        cmp_ctrl.restart        = lane_ctrl.restart;
        cmp_ctrl.gen            = lane_ctrl.step;
        cmp_ctrl.check          = s1_adv && (s1_reg.mode == MODE_CHECK);
        cmp_ctrl.negative_phase = s1_reg.negative_phase;
    end

    mlprbs_lanes #(
        .LANES     (LANES),
        .MAX_ORDER (MAX_ORDER)
    ) u_lanes (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .cfg   (cfg_reg),
        .word  (lane_word)
    );

    mlprbs_cmp #(
        .LANES (LANES)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cmp_ctrl),
        .cfg       (cfg_reg),
        .word      (lane_word),
        .read_data (s1_reg.read_data),
        .rsp       (rsp_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            s1_reg <= cmd;
        if (s1_adv)
            rsp_reg <= rsp_calc;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/mlprbs_chk.sv -----
module mlprbs_chk (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic                    cmd_ready,
    input  logic                    rsp_valid,
    input  logic                    rsp_ready,
    input  mlprbs_pkg::rsp_word_t   rsp
);

    // a stalled rsp word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp word changed while stalled");

    // a flagged mismatch is always counted
    a_mis_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mismatch |-> rsp.error_count != '0)
        else $error("mismatch with zero error count");

    // cmd side only backs up when the result side is full
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> rsp_valid)
        else $error("cmd_ready low with empty result register");

    // a new rsp word traces back through the input register to a cmd word
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid, 2))
        else $error("rsp word with no cmd word behind it");

endmodule

bind multilane_prbs_pattern_gen_check_core mlprbs_chk u_mlprbs_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    import mlprbs_pkg::*;

    localparam int NUM_LANES    = 32;
    // two register stages through the core, plus margin
    localparam int DRAIN_CYCLES = 6;
    // watchdog limit, many times what the slowest legal run needs
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_IDLE     = 13;

    // read data choice for generate/check words
    localparam int RD_AS_GIVEN = 0;
    localparam int RD_MATCH    = 1;
    localparam int RD_ONE_FLIP = 2;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_word_t             cmd = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_word_t             rsp;

    // predictor state: lane shift registers, error counter, register copy
    logic [SEED_W-1:0]      lane_regs [NUM_LANES];
    logic [WORD_W-1:0]      err_total;
    logic [ORDER_SEL_W-1:0] order_sel;
    logic [LANE_IDX_W-1:0]  tgt_lane;
    logic                   rnd_lanes;

    rsp_word_t expected_rsp [$];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;

    multilane_prbs_pattern_gen_check_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Pattern predictor
    //------------------------------------------------------------------

    // order length n; output is stage n-1, feedback taps n-1 and t-1
    function automatic int order_len(input logic [ORDER_SEL_W-1:0] sel);
        case (sel)
            SEL_PRBS7:  return 7;
            SEL_PRBS15: return 15;
            SEL_PRBS23: return 23;
            default:    return 31;
        endcase
    endfunction

    function automatic int order_tap(input logic [ORDER_SEL_W-1:0] sel);
        case (sel)
            SEL_PRBS7:  return 3;
            SEL_PRBS15: return 1;
            SEL_PRBS23: return 5;
            default:    return 3;
        endcase
    endfunction

    function automatic void restart_lanes();
        for (int j = 0; j < NUM_LANES; j++)
            lane_regs[j] = STD_SEED;
        err_total = '0;
    endfunction

    // word the lanes will emit next, without stepping them
    function automatic logic [WORD_W-1:0] next_pattern(input logic neg);
        logic [WORD_W-1:0] w;
        int                n;
        n = order_len(order_sel);
        w = '0;
        for (int j = 0; j < NUM_LANES; j++)
            w[j] = lane_regs[j][n-1];
        if (neg)
            w[tgt_lane] = ~w[tgt_lane];
        return w;
    endfunction

    // all 31 stages shift, whatever the order
    function automatic void advance_lanes();
        int n;
        int t;
        n = order_len(order_sel);
        t = order_tap(order_sel);
        for (int j = 0; j < NUM_LANES; j++)
            lane_regs[j] = {lane_regs[j][SEED_W-2:0], lane_regs[j][n-1] ^ lane_regs[j][t-1]};
    endfunction

    function automatic rsp_word_t apply_word(input cmd_word_t w);
        rsp_word_t r;
        r = '0;
        case (w.mode)
            MODE_RESTART:
                restart_lanes();
            MODE_SEED:
            begin
                // a seed for the target lane is refused, as is any seed with random lanes off
                if (rnd_lanes && w.lane != tgt_lane)
                    lane_regs[w.lane] = w.seed;
            end
            default:
            begin
                r.pattern = next_pattern(w.negative_phase);
                advance_lanes();
                if (w.mode == MODE_CHECK && w.read_data != r.pattern)
                begin
                    r.mismatch = 1'b1;
                    if (err_total != '1)
                        err_total = err_total + WORD_W'(1);
                end
            end
        endcase
        r.error_count = err_total;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Shared driving tasks
    //------------------------------------------------------------------

    function automatic cmd_word_t rand_cmd(input logic [MODE_W-1:0] m);
        cmd_word_t w;
        w.mode           = m;
        w.lane           = LANE_IDX_W'($urandom);
        w.seed           = SEED_W'($urandom);
        w.negative_phase = 1'($urandom);
        w.read_data      = $urandom;
        return w;
    endfunction

    // called at a clock edge; returns at the edge that accepts the word
    task automatic send_word(input cmd_word_t w, input int rd_sel);
        int gap;
        if (w.mode == MODE_GEN || w.mode == MODE_CHECK)
        begin
            if (rd_sel == RD_MATCH)
                w.read_data = next_pattern(w.negative_phase);
            else if (rd_sel == RD_ONE_FLIP)
                w.read_data = next_pattern(w.negative_phase) ^ (32'd1 << $urandom_range(0, 31));
        end
        expected_rsp.push_back(apply_word(w));
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // registers change only with the core empty
    task automatic set_config(input logic [ORDER_SEL_W-1:0] o, input logic [LANE_IDX_W-1:0] t,
                              input logic r);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ORDER_SELECT;
        // upper data bits are don't-care for the narrow registers
        cfg_wdata <= {(CFG_DATA_W-ORDER_SEL_W)'($urandom), o};
        @(posedge clk);
        cfg_index <= CFG_TARGET_LANE;
        cfg_wdata <= t;
        @(posedge clk);
        cfg_index <= CFG_RANDOM_LANES;
        cfg_wdata <= {(CFG_DATA_W-1)'($urandom), r};
        @(posedge clk);
        cfg_we    <= 1'b0;
        order_sel = o;
        tgt_lane  = t;
        rnd_lanes = r;
        @(posedge clk);
    endtask

    //------------------------------------------------------------------
    // Response side: random stalls, compare with oldest expectation
    //------------------------------------------------------------------

    task automatic check_rsp(input rsp_word_t got);
        rsp_word_t want;
        if (expected_rsp.size() == 0)
        begin
            $error("unexpected response word %h", got);
            fail_count++;
        end
        else
        begin
            want = expected_rsp.pop_front();
            if (got.pattern !== want.pattern)
            begin
                $error("pattern: expected %h actual %h", want.pattern, got.pattern);
                fail_count++;
            end
            if (got.mismatch !== want.mismatch)
            begin
                $error("mismatch: expected %0d actual %0d", want.mismatch, got.mismatch);
                fail_count++;
            end
            if (got.error_count !== want.error_count)
            begin
                $error("error_count: expected %0d actual %0d", want.error_count,
                       got.error_count);
                fail_count++;
            end
        end
    endtask

    initial
    begin : rsp_side
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            check_rsp(rsp);
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // reset values: PRBS7, target lane 0, random lanes on
    task automatic test_reset_defaults();
        cmd_word_t w;
        w = rand_cmd(MODE_GEN);
        w.negative_phase = 1'b0;
        send_word(w, RD_AS_GIVEN);
        w.negative_phase = 1'b1;
        send_word(w, RD_AS_GIVEN);
        w = rand_cmd(MODE_CHECK);
        send_word(w, RD_MATCH);
        send_word(rand_cmd(MODE_CHECK), RD_ONE_FLIP);
        w = rand_cmd(MODE_CHECK);
        w.read_data = '0;
        send_word(w, RD_AS_GIVEN);
        w.read_data = '1;
        send_word(w, RD_AS_GIVEN);
        send_word(rand_cmd(MODE_GEN), RD_AS_GIVEN);
    endtask

    // seed accepted, refused for the target lane and with random lanes off
    task automatic test_seed_loading();
        cmd_word_t w;
        send_word(rand_cmd(MODE_RESTART), RD_AS_GIVEN);
        w = rand_cmd(MODE_SEED);
        w.lane = '1;
        w.seed = '1;
        send_word(w, RD_AS_GIVEN);
        w.lane = 5'd1;
        w.seed = '0;
        send_word(w, RD_AS_GIVEN);
        w = rand_cmd(MODE_SEED);
        w.lane = '0;
        send_word(w, RD_AS_GIVEN);
        send_word(rand_cmd(MODE_GEN), RD_AS_GIVEN);
        send_word(rand_cmd(MODE_CHECK), RD_MATCH);
        set_config(SEL_PRBS15, 5'd0, 1'b0);
        w = rand_cmd(MODE_SEED);
        w.lane = 5'd2;
        send_word(w, RD_AS_GIVEN);
        send_word(rand_cmd(MODE_CHECK), RD_ONE_FLIP);
    endtask

    // top order, top target lane; stale upper stages carried across orders
    task automatic test_order_and_target();
        cmd_word_t w;
        set_config(SEL_PRBS31, 5'd31, 1'b1);
        w = rand_cmd(MODE_GEN);
        w.negative_phase = 1'b1;
        send_word(w, RD_AS_GIVEN);
        w = rand_cmd(MODE_CHECK);
        w.negative_phase = 1'b1;
        send_word(w, RD_MATCH);
        send_word(rand_cmd(MODE_CHECK), RD_ONE_FLIP);
        set_config(SEL_PRBS23, 5'd16, 1'b1);
        w = rand_cmd(MODE_SEED);
        w.lane = 5'd16;
        send_word(w, RD_AS_GIVEN);
        w = rand_cmd(MODE_GEN);
        w.negative_phase = 1'b1;
        send_word(w, RD_AS_GIVEN);
        send_word(rand_cmd(MODE_CHECK), RD_ONE_FLIP);
    endtask

    // random mix of restart, seed, generate and check words; most checks match, the rest flip a bit or use random data
    task automatic test_random_traffic();
        int sel;
        logic [ORDER_SEL_W-1:0] o;
        logic [LANE_IDX_W-1:0]  t;
        logic                   r;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
            begin
                o = SEL_PRBS7;
                t = '0;
                r = 1'b1;
            end
            else if (ph == 1)
            begin
                o = SEL_PRBS31;
                t = '1;
                r = 1'b0;
            end
            else
            begin
                o = ORDER_SEL_W'($urandom);
                t = LANE_IDX_W'($urandom);
                r = ($urandom_range(0, 3) != 0);
            end
            set_config(o, t, r);
            // every third phase runs back to back on both sides
            idle_on = (ph % 3) != 2;
            if ($urandom_range(0, 3) != 0)
                send_word(rand_cmd(MODE_RESTART), RD_AS_GIVEN);
            for (int k = 0; k < 162; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 5)
                    send_word(rand_cmd(MODE_RESTART), RD_AS_GIVEN);
                else if (sel < 20)
                    send_word(rand_cmd(MODE_SEED), RD_AS_GIVEN);
                else if (sel < 45)
                    send_word(rand_cmd(MODE_GEN), RD_AS_GIVEN);
                else if (sel < 80)
                    send_word(rand_cmd(MODE_CHECK), RD_MATCH);
                else if (sel < 90)
                    send_word(rand_cmd(MODE_CHECK), RD_ONE_FLIP);
                else
                    send_word(rand_cmd(MODE_CHECK), RD_AS_GIVEN);
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin : main_seq
        order_sel = SEL_PRBS7;
        tgt_lane  = '0;
        rnd_lanes = 1'b1;
        restart_lanes();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_seed_loading();
        test_order_and_target();
        test_random_traffic();
        wait_drained();

        if (expected_rsp.size() != 0)
        begin
            $error("%0d response words never arrived", expected_rsp.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mlprbs_pkg.sv
rtl/mlprbs_lanes.sv
rtl/mlprbs_cmp.sv
rtl/multilane_prbs_pattern_gen_check_core.sv
rtl/mlprbs_chk.sv
tb/testbench.sv
